// ----- rtl/apdd_pkg.sv -----
// Types, constants and the squared-cosine table for the angle/power drive mixer.
// No dependencies; used by angle_power_to_differential_drive.
package apdd_pkg;

  typedef struct packed {
    logic signed [15:0] direction;
    logic        [7:0]  power;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } out_beat_t;

  // Offset that makes any 16-bit signed angle non-negative, a multiple of 360.
  localparam int unsigned DirOffset = 33120;
  // ceil(2^25 / 360): exact quotient for every offset angle below 2^17.
  localparam int unsigned Recip360 = 93207;
  localparam int unsigned Recip360Shift = 25;
  // floor(2^27 / 255): quotient low by at most one, fixed by one compare.
  localparam int unsigned Recip255 = 526344;
  localparam int unsigned Recip255Shift = 27;
  localparam int unsigned Recip255W = 20;

  localparam int unsigned Q30One = 32'h4000_0000;
  localparam int unsigned DegToRadQ30 = 18740330;

  // cos^2 of 0..90 degrees, Q30 (2^30 at zero degrees, so 31 bits).
  typedef logic [90:0][30:0] c2_table_t;

  function automatic c2_table_t build_c2_table();
    c2_table_t   tbl;
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] v;
    logic [63:0] one;
    logic [63:0] c2;
    one = 64'(Q30One);
    for (int r = 0; r <= 90; r++) begin
      t  = (r > 45) ? 64'(90 - r) : 64'(r);
      x  = t * 64'(DegToRadQ30);
      x2 = (x * x) >> 30;
      if (r <= 45) begin
        h = one - x2 / 56;
        h = one - ((x2 * h) >> 30) / 30;
        h = one - ((x2 * h) >> 30) / 12;
        v = one - ((x2 * h) >> 30) / 2;
      end else begin
        h = one - x2 / 72;
        h = one - ((x2 * h) >> 30) / 42;
        h = one - ((x2 * h) >> 30) / 20;
        h = one - ((x2 * h) >> 30) / 6;
        v = (x * h) >> 30;
      end
      c2 = (v * v) >> 30;
      tbl[r] = c2[30:0];
    end
    return tbl;
  endfunction

  localparam c2_table_t C2Table = build_c2_table();

endpackage

// ----- rtl/angle_power_to_differential_drive.sv -----
// Angle/power to differential drive: 7-stage pipeline, one beat per cycle while out_ready_i is high.
// out_valid_o rises once an accepted beat has passed through every stage register,
// and the result beat is taken on an edge where out_ready_i is high; throughput is one
// beat per cycle while out_ready_i is high, set by the fully pipelined datapath.
// Each stage holds its beat under back-pressure and fills bubbles upstream.
// Reset (rst_ni low, asynchronous) clears the stage valid bits only.
module angle_power_to_differential_drive #(
  parameter int unsigned OUT_FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  apdd_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output apdd_pkg::out_beat_t out_data_o
);

  localparam int unsigned NStg  = 7;
  localparam int unsigned MagW  = 46;                      // |A| (31b) * power*100 (15b)
  localparam int unsigned SumW  = MagW + OUT_FRAC_BITS + 1;
  localparam int unsigned WW    = SumW - 30;               // rounded, pre-/255 value
  localparam int unsigned QW    = WW - 7;                  // quotient estimate
  localparam int unsigned PrW   = WW + apdd_pkg::Recip255W;

  // ---------------------------------------------------------------------------
  // Flow control: stage k loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------------
  logic [NStg-1:0] v_q;
  logic [NStg:0]   en;

  always_comb begin
    en[NStg] = out_ready_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: offset the angle positive, quotient by 360 via reciprocal.
  // ---------------------------------------------------------------------------
  logic [16:0] u_d, u1_q;
  logic [33:0] q360_prod;
  logic [7:0]  q1_q;
  logic [7:0]  pw1_q;

  assign u_d       = 17'(int'(in_data_i.direction) + int'(apdd_pkg::DirOffset));
  assign q360_prod = 34'(u_d) * 34'(apdd_pkg::Recip360);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      u1_q  <= u_d;
      q1_q  <= q360_prod[apdd_pkg::Recip360Shift +: 8];
      pw1_q <= in_data_i.power;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: remainder 0..359, fold into 0..90, quadrant signs.
  // ---------------------------------------------------------------------------
  logic [16:0] rem360;
  logic [8:0]  deg;
  logic [6:0]  r_d, r2_q;
  logic        cz_d, cn_d, sz_d, sn_d;
  logic        cz2_q, cn2_q, sz2_q, sn2_q;
  logic [7:0]  pw2_q;

  assign rem360 = u1_q - 17'(q1_q) * 17'(360);
  assign deg    = rem360[8:0];

  always_comb begin
    priority if (deg <= 9'd90) begin
      r_d = 7'(deg);
    end else if (deg <= 9'd180) begin
      r_d = 7'(9'd180 - deg);
    end else if (deg <= 9'd270) begin
      r_d = 7'(deg - 9'd180);
    end else begin
      r_d = 7'(9'd360 - deg);
    end
    cz_d = (deg == 9'd90) || (deg == 9'd270);
    cn_d = (deg > 9'd90) && (deg < 9'd270);
    sz_d = (deg == 9'd0) || (deg == 9'd180);
    sn_d = (deg > 9'd180);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      r2_q  <= r_d;
      cz2_q <= cz_d;
      cn2_q <= cn_d;
      sz2_q <= sz_d;
      sn2_q <= sn_d;
      pw2_q <= pw1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: table lookup, signed long/lat mix, power * 100.
  // ---------------------------------------------------------------------------
  logic [30:0]        c2, s2;
  logic signed [31:0] lon, lat;
  logic signed [31:0] al3_q, ar3_q;
  logic [14:0]        p3_q;

  assign c2 = apdd_pkg::C2Table[r2_q];
  assign s2 = 31'(apdd_pkg::Q30One) - c2;

  always_comb begin
    lon = cz2_q ? 32'sd0 : (cn2_q ? -$signed({1'b0, c2}) : $signed({1'b0, c2}));
    lat = sz2_q ? 32'sd0 : (sn2_q ? -$signed({1'b0, s2}) : $signed({1'b0, s2}));
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      al3_q <= lon - lat;
      ar3_q <= lon + lat;
      p3_q  <= 15'(pw2_q) * 15'(100);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: magnitude times scaled power; sign kept aside.
  // ---------------------------------------------------------------------------
  logic [30:0]     absl, absr;
  logic [MagW-1:0] ml4_q, mr4_q;
  logic            nl4_q, nr4_q;

  assign absl = al3_q[31] ? 31'(-al3_q) : al3_q[30:0];
  assign absr = ar3_q[31] ? 31'(-ar3_q) : ar3_q[30:0];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      ml4_q <= MagW'(absl) * MagW'(p3_q);
      mr4_q <= MagW'(absr) * MagW'(p3_q);
      nl4_q <= al3_q[31];
      nr4_q <= ar3_q[31];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: shift in fraction bits, add half of 255*2^30, drop 30 bits.
  // ---------------------------------------------------------------------------
  localparam logic [SumW-1:0] Round = SumW'(255) << 29;
  logic [SumW-1:0] suml, sumr;
  logic [WW-1:0]   wl5_q, wr5_q;
  logic            nl5_q, nr5_q;

  assign suml = (SumW'(ml4_q) << OUT_FRAC_BITS) + Round;
  assign sumr = (SumW'(mr4_q) << OUT_FRAC_BITS) + Round;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      wl5_q <= suml[SumW-1:30];
      wr5_q <= sumr[SumW-1:30];
      nl5_q <= nl4_q;
      nr5_q <= nr4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: quotient estimate by 255, low by at most one.
  // ---------------------------------------------------------------------------
  logic [PrW-1:0] prl, prr;
  logic [QW-1:0]  ql6_q, qr6_q;
  logic [WW-1:0]  wl6_q, wr6_q;
  logic           nl6_q, nr6_q;

  assign prl = PrW'(wl5_q) * PrW'(apdd_pkg::Recip255);
  assign prr = PrW'(wr5_q) * PrW'(apdd_pkg::Recip255);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      ql6_q <= prl[apdd_pkg::Recip255Shift +: QW];
      qr6_q <= prr[apdd_pkg::Recip255Shift +: QW];
      wl6_q <= wl5_q;
      wr6_q <= wr5_q;
      nl6_q <= nl5_q;
      nr6_q <= nr5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: quotient correction, sign, saturation into the output register.
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] finish(logic [WW-1:0] w, logic [QW-1:0] q0, logic neg);
    logic [WW-1:0] rem;
    logic [31:0]   q;
    logic [15:0]   res;
    rem = w - WW'(q0) * WW'(255);
    q   = 32'(q0) + ((rem >= WW'(255)) ? 32'd1 : 32'd0);
    if (neg) begin
      res = (q > 32'd32768) ? 16'h8000 : 16'(32'd0 - q);
    end else begin
      res = (q > 32'd32767) ? 16'h7fff : q[15:0];
    end
    return res;
  endfunction

  apdd_pkg::out_beat_t out_d, out_q;

  always_comb begin
    out_d.left_speed  = $signed(finish(wl6_q, ql6_q, nl6_q));
    out_d.right_speed = $signed(finish(wr6_q, qr6_q, nr6_q));
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule
